@@ rtl/core/cspdp_pkg.sv @@
// shared constants, types and the edge cost function of the column shortest-path stage
// no dependencies
package cspdp_pkg;

    localparam int MAX_ROWS   = 1024;
    localparam int COST_BITS  = 16;
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int CNT_BITS   = 11;
    localparam int MIN_ROWS   = 4;
    localparam int OUT_BYTES  = (ROW_BITS + COST_BITS + ROW_BITS + ROW_BITS + 7) / 8;
    localparam int OUT_PAD    = OUT_BYTES * 8 - (ROW_BITS + COST_BITS + ROW_BITS + ROW_BITS);

    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [ROW_BITS-1:0]  row_t;

    // one entry of the column store
    typedef struct packed {
        cost_t cost;
        logic  black;
        row_t  origin;
    } col_entry_t;

    // cost of reaching a pixel from one neighbour, saturating
    function automatic cost_t step_cost(input cost_t nb_cost, input logic nb_black,
                                        input logic px_black, input logic diag);
        logic [3:0]         w;
        logic [COST_BITS:0] sum;
        w   = 4'd2 + (px_black ? 4'd1 : 4'd2) + (nb_black ? 4'd1 : 4'd2)
              + (diag ? 4'd2 : 4'd0);
        sum = {1'b0, nb_cost} + (COST_BITS + 1)'(w);
        return sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/column_shortest_path_dp_top.sv @@
// column shortest-path stage: two-bank column store, read/compute pipeline, output register
// depends on cspdp_pkg
//
// Takes one pixel per clock unless the output is stalled, column by column with the top row
// first, and returns one result per pixel: its row, the cheapest path cost into it, the chosen
// row in the previous column and the first-column row where that path began. Sustained rate is
// one pixel per cycle while m_axis_tready keeps the output draining, set by the column store,
// which serves two reads (rows r and r+1 of the previous column) and one write (row r of the
// current column) each cycle; row r-1 is kept from the pixel before. A result passes through the
// stage-two registers and then the output register. The row counter advances on every pixel and
// the banks swap after the last row, so images must consist of whole columns; the first-column
// flag only selects the start values. The row count may be changed only while no pixel is in flight.
module column_shortest_path_dp_top
    import cspdp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CNT_BITS-1:0]      cfg_wr_data,     // row_count
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,    // pixel_value
    input  logic                     s_axis_tuser,    // first_column
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_BYTES*8-1:0]   m_axis_tdata     // row_index, path_cost, pred_row, start_row
);

    col_entry_t col_mem [0:2*MAX_ROWS-1];

    logic [CNT_BITS-1:0] row_count_reg;
    row_t                cur_row_reg;
    logic                bank_reg;

    logic                s2_valid_reg;
    row_t                s2_row_reg;
    logic                s2_bank_reg;
    logic                s2_black_reg;
    logic                s2_first_reg;
    logic                s2_has_up_reg;
    logic                s2_has_down_reg;
    col_entry_t          rd_mid_reg;
    col_entry_t          rd_down_reg;
    col_entry_t          up_reg;

    logic                out_valid_reg;
    row_t                out_row_reg;
    cost_t               out_cost_reg;
    row_t                out_pred_reg;
    row_t                out_start_reg;

    logic [CNT_BITS-1:0] rows_used;
    logic [CNT_BITS-1:0] row_plus_one;
    logic                in_xfer;
    logic                s2_adv;
    logic                last_row;

    cost_t               c_up;
    cost_t               c_mid;
    cost_t               c_down;
    cost_t               best_cost;
    row_t                best_pred;
    row_t                best_origin;
    col_entry_t          wr_entry;

    always_comb
    begin
        if (row_count_reg < CNT_BITS'(MIN_ROWS))
            rows_used = CNT_BITS'(MIN_ROWS);
        else if (row_count_reg > CNT_BITS'(MAX_ROWS))
            rows_used = CNT_BITS'(MAX_ROWS);
        else
            rows_used = row_count_reg;
    end

    assign row_plus_one  = CNT_BITS'(cur_row_reg) + CNT_BITS'(1);
    assign last_row      = row_plus_one >= rows_used;

    assign s2_adv        = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s2_valid_reg || s2_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_BITS'(MAX_ROWS);
            cur_row_reg   <= '0;
            bank_reg      <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                row_count_reg <= cfg_wr_data;
            if (in_xfer)
            begin
                if (last_row)
                begin
                    cur_row_reg <= '0;
                    bank_reg    <= ~bank_reg;
                end
                else
                begin
                    cur_row_reg <= cur_row_reg + ROW_BITS'(1);
                end
            end
            if (in_xfer)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;
            if (s2_adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // column store: reads from the previous bank on a transfer, written back from stage two
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rd_mid_reg  <= col_mem[{bank_reg, cur_row_reg}];
            rd_down_reg <= col_mem[{bank_reg, cur_row_reg + ROW_BITS'(1)}];
        end
        if (s2_adv)
            col_mem[{s2_bank_reg, s2_row_reg}] <= wr_entry;
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s2_row_reg      <= cur_row_reg;
            s2_bank_reg     <= ~bank_reg;
            s2_black_reg    <= (s_axis_tdata == 8'd0);
            s2_first_reg    <= s_axis_tuser;
            s2_has_up_reg   <= (cur_row_reg != '0);
            s2_has_down_reg <= !last_row;
        end
        // row r of the previous column serves as the upper neighbour of row r+1
        if (s2_adv)
            up_reg <= rd_mid_reg;
    end

    always_comb
    begin
        c_up   = step_cost(up_reg.cost, up_reg.black, s2_black_reg, 1'b1);
        c_mid  = step_cost(rd_mid_reg.cost, rd_mid_reg.black, s2_black_reg, 1'b0);
        c_down = step_cost(rd_down_reg.cost, rd_down_reg.black, s2_black_reg, 1'b1);

        // straight wins ties, the upper diagonal beats the lower one
        best_cost   = c_mid;
        best_pred   = s2_row_reg;
        best_origin = rd_mid_reg.origin;
        if (s2_has_up_reg && (c_up < c_mid))
        begin
            best_cost   = c_up;
            best_pred   = s2_row_reg - ROW_BITS'(1);
            best_origin = up_reg.origin;
        end
        if (s2_has_down_reg && (c_down < best_cost))
        begin
            best_cost   = c_down;
            best_pred   = s2_row_reg + ROW_BITS'(1);
            best_origin = rd_down_reg.origin;
        end
        if (s2_first_reg)
        begin
            best_cost   = '0;
            best_pred   = '0;
            best_origin = s2_row_reg;
        end

        wr_entry.cost   = best_cost;
        wr_entry.black  = s2_black_reg;
        wr_entry.origin = best_origin;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_row_reg   <= s2_row_reg;
            out_cost_reg  <= best_cost;
            out_pred_reg  <= best_pred;
            out_start_reg <= best_origin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_start_reg, out_pred_reg, out_cost_reg,
                            out_row_reg};

endmodule
